// ----- hw/rtl/sle_pkg.sv -----
package sle_pkg;

   // result kinds
   localparam logic [1:0] KIND_ECHO  = 2'd0;
   localparam logic [1:0] KIND_ERASE = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;
   localparam logic [1:0] KIND_LINE  = 2'd3;

   // decoded key operations
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_ERASE = 3'd1;
   localparam logic [2:0] OP_TAB   = 3'd2;
   localparam logic [2:0] OP_CLEAR = 3'd3;
   localparam logic [2:0] OP_ENTER = 3'd4;
   localparam logic [2:0] OP_PRINT = 3'd5;

   // character source for the result register and the line store
   localparam logic [2:0] SEL_ZERO    = 3'd0;
   localparam logic [2:0] SEL_KEY     = 3'd1;
   localparam logic [2:0] SEL_SPACE   = 3'd2;
   localparam logic [2:0] SEL_STORE   = 3'd3;
   localparam logic [2:0] SEL_NEWLINE = 3'd4;

   // set-1 scancodes with special meaning
   localparam logic [7:0] SC_CAPS       = 8'h3A;
   localparam logic [7:0] SC_CAPS_REL   = 8'hBA;
   localparam logic [7:0] SC_LSHIFT     = 8'h2A;
   localparam logic [7:0] SC_RSHIFT     = 8'h36;
   localparam logic [7:0] SC_LSHIFT_REL = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_REL = 8'hB6;
   localparam logic [7:0] SC_CTRL       = 8'h1D;
   localparam logic [7:0] SC_CTRL_REL   = 8'h9D;
   localparam logic [7:0] SC_BACKSPACE  = 8'h0E;
   localparam logic [7:0] SC_TAB        = 8'h0F;
   localparam logic [7:0] SC_MAP_ROWS   = 8'd58;

   localparam logic [6:0] CH_NEWLINE = 7'h0A;
   localparam logic [6:0] CH_SPACE   = 7'h20;
   localparam logic [6:0] CH_LOWER_L = 7'h6C;
   localparam logic [6:0] CH_UPPER_L = 7'h4C;

   typedef struct packed {
      logic       accept;
      logic       push;
      logic [1:0] kind;
      logic [2:0] sel;
      logic       last;
      logic       store;
      logic       pop;
      logic       clear;
      logic       idx_inc;
      logic       rd;
   } sle_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       fill_zero;
      logic       fill_full;
      logic       fill_near;
      logic       idx_last;
      logic       out_free;
   } sle_stat_type;

   // Key table row: {letter, unshifted, shifted}. Letters swap case under caps lock,
   // other keys ignore caps lock.
   function automatic logic [14:0] key_row(input logic [5:0] row);
      logic [6:0] lc;
      logic [14:0] ent;
      lc  = 7'h00;
      ent = 15'd0;
      case (row)
         6'd2:  ent = {1'b0, 7'h31, 7'h21};
         6'd3:  ent = {1'b0, 7'h32, 7'h40};
         6'd4:  ent = {1'b0, 7'h33, 7'h23};
         6'd5:  ent = {1'b0, 7'h34, 7'h24};
         6'd6:  ent = {1'b0, 7'h35, 7'h25};
         6'd7:  ent = {1'b0, 7'h36, 7'h5E};
         6'd8:  ent = {1'b0, 7'h37, 7'h26};
         6'd9:  ent = {1'b0, 7'h38, 7'h2A};
         6'd10: ent = {1'b0, 7'h39, 7'h28};
         6'd11: ent = {1'b0, 7'h30, 7'h29};
         6'd12: ent = {1'b0, 7'h2D, 7'h5F};
         6'd13: ent = {1'b0, 7'h3D, 7'h2B};
         6'd16: lc = 7'h71;
         6'd17: lc = 7'h77;
         6'd18: lc = 7'h65;
         6'd19: lc = 7'h72;
         6'd20: lc = 7'h74;
         6'd21: lc = 7'h79;
         6'd22: lc = 7'h75;
         6'd23: lc = 7'h69;
         6'd24: lc = 7'h6F;
         6'd25: lc = 7'h70;
         6'd26: ent = {1'b0, 7'h5B, 7'h7B};
         6'd27: ent = {1'b0, 7'h5D, 7'h7D};
         6'd28: ent = {1'b0, CH_NEWLINE, CH_NEWLINE};
         6'd30: lc = 7'h61;
         6'd31: lc = 7'h73;
         6'd32: lc = 7'h64;
         6'd33: lc = 7'h66;
         6'd34: lc = 7'h67;
         6'd35: lc = 7'h68;
         6'd36: lc = 7'h6A;
         6'd37: lc = 7'h6B;
         6'd38: lc = 7'h6C;
         6'd39: ent = {1'b0, 7'h3B, 7'h3A};
         6'd40: ent = {1'b0, 7'h27, 7'h22};
         6'd41: ent = {1'b0, 7'h60, 7'h7E};
         6'd43: ent = {1'b0, 7'h5C, 7'h7C};
         6'd44: lc = 7'h7A;
         6'd45: lc = 7'h78;
         6'd46: lc = 7'h63;
         6'd47: lc = 7'h76;
         6'd48: lc = 7'h62;
         6'd49: lc = 7'h6E;
         6'd50: lc = 7'h6D;
         6'd51: ent = {1'b0, 7'h2C, 7'h3C};
         6'd52: ent = {1'b0, 7'h2E, 7'h3E};
         6'd53: ent = {1'b0, 7'h2F, 7'h3F};
         6'd57: ent = {1'b0, CH_SPACE, CH_SPACE};
         default: ent = 15'd0;
      endcase
      if (lc != 7'h00) begin
         ent = {1'b1, lc, lc ^ 7'h20};
      end
      return ent;
   endfunction

endpackage

// ----- hw/rtl/scancode_line_editor_core.sv -----
// Response: rsp_valid rises once the ERASE, CLEAR, PUT or NL state entered on acceptance
// pushes its beat, which waits while the result register is still occupied; the first
// beat of a non-empty enter comes after a line store read in the READ state.
// Acceptance: req_ready is high only in the idle state; a key with no result leaves it
// idle, while echo, erase, clear, tab (up to four spaces) and enter hold it off until
// their last beat is pushed, each stored character taking a line store read and its beat.
// Reset clears shift, ctrl, caps lock, the fill count, the read index and the result valid flag;
// the line store itself is not cleared.
module scancode_line_editor_core #(
   parameter int LINE_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_scancode,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [6:0] rsp_character,
   output logic       rsp_last
);

   sle_pkg::sle_cmd_type  cmd;
   sle_pkg::sle_stat_type stat;

   sle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sle_datapath #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_scancode  (req_scancode),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

// ----- hw/rtl/sle_ctrl.sv -----
module sle_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sle_pkg::sle_stat_type stat,
   output sle_pkg::sle_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ERASE = 3'd1;
   localparam logic [2:0] S_CLEAR = 3'd2;
   localparam logic [2:0] S_PUT   = 3'd3;
   localparam logic [2:0] S_TAB   = 3'd4;
   localparam logic [2:0] S_READ  = 3'd5;
   localparam logic [2:0] S_LINE  = 3'd6;
   localparam logic [2:0] S_NL    = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [1:0] tab_cnt_ff, tab_cnt_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in   = state_ff;
      tab_cnt_in = tab_cnt_ff;
      cmd        = '0;
      cmd.accept = accept;
      case (state_ff)
         S_IDLE: begin
            tab_cnt_in = 2'd0;
            if (accept) begin
               case (stat.op)
                  sle_pkg::OP_ERASE: state_in = stat.fill_zero ? S_IDLE : S_ERASE;
                  sle_pkg::OP_TAB:   state_in = stat.fill_full ? S_IDLE : S_TAB;
                  sle_pkg::OP_CLEAR: state_in = S_CLEAR;
                  sle_pkg::OP_ENTER: state_in = stat.fill_zero ? S_NL : S_READ;
                  sle_pkg::OP_PRINT: state_in = stat.fill_full ? S_IDLE : S_PUT;
                  default:           state_in = S_IDLE;
               endcase
            end
         end
         S_ERASE: begin
            if (stat.out_free) begin
               cmd.push = 1'b1;
               cmd.kind = sle_pkg::KIND_ERASE;
               cmd.sel  = sle_pkg::SEL_ZERO;
               cmd.last = 1'b1;
               cmd.pop  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_CLEAR: begin
            if (stat.out_free) begin
               cmd.push  = 1'b1;
               cmd.kind  = sle_pkg::KIND_CLEAR;
               cmd.sel   = sle_pkg::SEL_ZERO;
               cmd.last  = 1'b1;
               cmd.clear = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_PUT: begin
            if (stat.out_free) begin
               cmd.push  = 1'b1;
               cmd.kind  = sle_pkg::KIND_ECHO;
               cmd.sel   = sle_pkg::SEL_KEY;
               cmd.last  = 1'b1;
               cmd.store = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_TAB: begin
            if (stat.out_free) begin
               // stop after the fourth space or when this one fills the line
               cmd.push   = 1'b1;
               cmd.kind   = sle_pkg::KIND_ECHO;
               cmd.sel    = sle_pkg::SEL_SPACE;
               cmd.last   = (tab_cnt_ff == 2'd3) || stat.fill_near;
               cmd.store  = 1'b1;
               tab_cnt_in = tab_cnt_ff + 2'd1;
               if (cmd.last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_LINE;
         end
         S_LINE: begin
            if (stat.out_free) begin
               cmd.push    = 1'b1;
               cmd.kind    = sle_pkg::KIND_LINE;
               cmd.sel     = sle_pkg::SEL_STORE;
               cmd.idx_inc = 1'b1;
               state_in    = stat.idx_last ? S_NL : S_READ;
            end
         end
         S_NL: begin
            if (stat.out_free) begin
               cmd.push  = 1'b1;
               cmd.kind  = sle_pkg::KIND_LINE;
               cmd.sel   = sle_pkg::SEL_NEWLINE;
               cmd.last  = 1'b1;
               cmd.clear = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         tab_cnt_ff <= 2'd0;
      end else begin
         state_ff   <= state_in;
         tab_cnt_ff <= tab_cnt_in;
      end
   end

   ctrl_no_push_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !cmd.push)
      else $error("result pushed while idle");

   ctrl_read_then_line: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |=> (state_ff == S_LINE))
      else $error("store read not followed by line output");

   ctrl_tab_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TAB && cmd.push && tab_cnt_ff == 2'd3) |=> (state_ff == S_IDLE))
      else $error("tab emitted more than four spaces");

endmodule

// ----- hw/rtl/sle_datapath.sv -----
module sle_datapath #(
   parameter int LINE_DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_scancode,
   input  sle_pkg::sle_cmd_type  cmd,
   output sle_pkg::sle_stat_type stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_kind,
   output logic [6:0]            rsp_character,
   output logic                  rsp_last
);

   localparam int FILL_W = $clog2(LINE_DEPTH + 1);
   localparam int ADDR_W = $clog2(LINE_DEPTH);

   logic              shift_ff, ctrl_ff, caps_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [ADDR_W-1:0] idx_ff;
   logic [6:0]        key_ff;
   logic [6:0]        rd_data_ff;
   logic [6:0]        line_mem [LINE_DEPTH];
   logic              rsp_valid_ff;
   logic [1:0]        rsp_kind_ff;
   logic [6:0]        rsp_char_ff;
   logic              rsp_last_ff;

   logic [14:0]       ent;
   logic              letter;
   logic [6:0]        ch_u, ch_s, key_char;
   logic [2:0]        op;
   logic [6:0]        sel_char;
   logic [FILL_W-1:0] idx_next;

   // map the incoming scancode with the modifier state as it stands
   always_comb begin
      ent    = sle_pkg::key_row(req_scancode[5:0]);
      letter = ent[14];
      ch_u   = ent[13:7];
      ch_s   = ent[6:0];
      case ({caps_ff, shift_ff})
         2'b00:   key_char = ch_u;
         2'b01:   key_char = ch_s;
         2'b10:   key_char = letter ? ch_s : ch_u;
         default: key_char = letter ? ch_u : ch_s;
      endcase
      op = sle_pkg::OP_NONE;
      if (req_scancode == sle_pkg::SC_BACKSPACE) begin
         op = sle_pkg::OP_ERASE;
      end else if (req_scancode == sle_pkg::SC_TAB) begin
         op = sle_pkg::OP_TAB;
      end else if (req_scancode inside {sle_pkg::SC_CAPS, sle_pkg::SC_CAPS_REL,
                                        sle_pkg::SC_LSHIFT, sle_pkg::SC_RSHIFT,
                                        sle_pkg::SC_LSHIFT_REL, sle_pkg::SC_RSHIFT_REL,
                                        sle_pkg::SC_CTRL, sle_pkg::SC_CTRL_REL}) begin
         op = sle_pkg::OP_NONE;
      end else if (req_scancode < sle_pkg::SC_MAP_ROWS && key_char != 7'h00) begin
         if (ctrl_ff && (key_char == sle_pkg::CH_LOWER_L ||
                         key_char == sle_pkg::CH_UPPER_L)) begin
            op = sle_pkg::OP_CLEAR;
         end else if (key_char == sle_pkg::CH_NEWLINE) begin
            op = sle_pkg::OP_ENTER;
         end else begin
            op = sle_pkg::OP_PRINT;
         end
      end
   end

   always_comb begin
      case (cmd.sel)
         sle_pkg::SEL_KEY:     sel_char = key_ff;
         sle_pkg::SEL_SPACE:   sel_char = sle_pkg::CH_SPACE;
         sle_pkg::SEL_STORE:   sel_char = rd_data_ff;
         sle_pkg::SEL_NEWLINE: sel_char = sle_pkg::CH_NEWLINE;
         default:              sel_char = 7'h00;
      endcase
   end

   assign idx_next       = FILL_W'(idx_ff) + FILL_W'(1);
   assign stat.op        = op;
   assign stat.fill_zero = (fill_ff == '0);
   assign stat.fill_full = (fill_ff == FILL_W'(LINE_DEPTH));
   assign stat.fill_near = (fill_ff == FILL_W'(LINE_DEPTH - 1));
   assign stat.idx_last  = (idx_next == fill_ff);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= 1'b0;
         ctrl_ff      <= 1'b0;
         caps_ff      <= 1'b0;
         fill_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            idx_ff <= '0;
            case (req_scancode)
               sle_pkg::SC_CAPS:       caps_ff  <= !caps_ff;
               sle_pkg::SC_LSHIFT:     shift_ff <= 1'b1;
               sle_pkg::SC_RSHIFT:     shift_ff <= 1'b1;
               sle_pkg::SC_LSHIFT_REL: shift_ff <= 1'b0;
               sle_pkg::SC_RSHIFT_REL: shift_ff <= 1'b0;
               sle_pkg::SC_CTRL:       ctrl_ff  <= 1'b1;
               sle_pkg::SC_CTRL_REL:   ctrl_ff  <= 1'b0;
               default: ;
            endcase
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + ADDR_W'(1);
         end
         if (cmd.clear) begin
            fill_ff <= '0;
         end else if (cmd.store) begin
            fill_ff <= fill_ff + FILL_W'(1);
         end else if (cmd.pop) begin
            fill_ff <= fill_ff - FILL_W'(1);
         end
         if (cmd.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload: key latch, result beat, line store
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         key_ff <= key_char;
      end
      if (cmd.push) begin
         rsp_kind_ff <= cmd.kind;
         rsp_char_ff <= sel_char;
         rsp_last_ff <= cmd.last;
      end
      if (cmd.store) begin
         line_mem[fill_ff[ADDR_W-1:0]] <= sel_char;
      end
      if (cmd.rd) begin
         rd_data_ff <= line_mem[idx_ff];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   dp_push_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!rsp_valid_ff || rsp_ready))
      else $error("result beat overwritten before it was taken");

   dp_store_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> !stat.fill_full)
      else $error("write into a full line store");

   dp_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !stat.fill_zero)
      else $error("erase from an empty line store");

endmodule
